[src/assert_macros.svh]
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/sitd_pkg.sv]
// Types and constants of the signed integer to decimal text block.
`default_nettype none

package sitd_pkg;

    localparam int DataW     = 64;
    localparam int NumDigits = 19;
    localparam int BcdW      = 4 * NumDigits;
    localparam int CntW      = $clog2(DataW);
    localparam int NdigW     = $clog2(NumDigits + 1);
    localparam int LenW      = 5;
    localparam int CharW     = 8;

    localparam logic [CharW-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CharW-1:0] CHAR_MINUS = 8'd45;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } t_conv_state;

    typedef struct packed {
        logic [BcdW-1:0]  bcd;
        logic [NdigW-1:0] ndig;
        logic             neg;
    } t_conv_result;

    // Double-dabble correction of one BCD digit.
    function automatic logic [3:0] add3(input logic [3:0] d);
        add3 = (d >= 4'd5) ? 4'(d + 4'd3) : d;
    endfunction

endpackage

`default_nettype wire

[src/sitd_dabble.sv]
// Bit-serial binary to BCD converter (shift-and-add-3), one bit per cycle.
`default_nettype none

module sitd_dabble (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [63:0]           i_value,
    input  wire logic                  i_take,
    output logic                       o_idle,
    output logic                       o_done,
    output sitd_pkg::t_conv_result     o_result
);
    import sitd_pkg::*;

    t_conv_state      r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [DataW-1:0] r_mag, n_mag;
    logic [BcdW-1:0]  r_bcd, n_bcd;
    logic [NdigW-1:0] r_ndig, n_ndig;
    logic             r_neg, n_neg;

    logic [BcdW-1:0]  corr;
    logic [BcdW-1:0]  shifted;
    logic             grow;

    // Correct every digit, then shift the next magnitude bit in.
    always_comb begin
        for (int i = 0; i < NumDigits; i++) begin
            corr[4*i +: 4] = add3(r_bcd[4*i +: 4]);
        end
        shifted = {corr[BcdW-2:0], r_mag[DataW-1]};
        // The value at most doubles per step, so the digit count grows by one at most.
        grow = 1'b0;
        for (int i = 0; i < NumDigits; i++) begin
            if (NdigW'(i) == r_ndig && shifted[4*i +: 4] != 4'd0) begin
                grow = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CONV_IDLE;
            r_cnt   <= '0;
            r_ndig  <= NdigW'(1);
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ndig  <= n_ndig;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
        r_bcd <= n_bcd;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_ndig  = r_ndig;
        n_neg   = r_neg;
        unique case (r_state)
            CONV_IDLE: begin
                if (i_start) begin
                    n_neg   = i_value[DataW-1];
                    n_mag   = i_value[DataW-1] ? (DataW'(0) - i_value) : i_value;
                    n_bcd   = '0;
                    n_ndig  = NdigW'(1);
                    n_cnt   = '0;
                    n_state = CONV_RUN;
                end
            end
            CONV_RUN: begin
                n_bcd = shifted;
                n_mag = {r_mag[DataW-2:0], 1'b0};
                n_cnt = CntW'(r_cnt + 1'b1);
                if (grow) begin
                    n_ndig = NdigW'(r_ndig + 1'b1);
                end
                if (r_cnt == CntW'(DataW - 1)) begin
                    n_state = CONV_DONE;
                end
            end
            CONV_DONE: begin
                if (i_take) begin
                    n_state = CONV_IDLE;
                end
            end
            default: begin
                n_state = CONV_IDLE;
            end
        endcase
    end

    assign o_idle        = (r_state == CONV_IDLE);
    assign o_done        = (r_state == CONV_DONE);
    assign o_result.bcd  = r_bcd;
    assign o_result.ndig = r_ndig;
    assign o_result.neg  = r_neg;

endmodule

`default_nettype wire

[src/signed_int_to_decimal_ascii.sv]
// A new number is taken only while the converter is idle; it runs the 64-step bit-serial
// converter, then waits for hand-over to the emitter, so the next number can enter once the
// hand-over is done; characters then leave one per cycle while the output is not stalled.
// Character emission overlaps with conversion of the next number.
// Reset: synchronous, active low; both stages come up empty, stall low.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_value,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_char_code,
    output logic             o_last,
    output logic [4:0]       o_length
);
    import sitd_pkg::*;

    `include "assert_macros.svh"

    logic         conv_idle;
    logic         conv_done;
    logic         conv_take;
    logic         in_accept;
    logic         out_accept;
    t_conv_result conv_res;

    // Emitter state: a digit shift line plus character bookkeeping.
    logic             r_ebusy,     n_ebusy;
    logic [BcdW-1:0]  r_edig,      n_edig;
    logic [NdigW-1:0] r_endig,     n_endig;
    logic             r_sign_pend, n_sign_pend;
    logic [LenW-1:0]  r_len,       n_len;
    logic [LenW-1:0]  r_rem,       n_rem;

    logic [NdigW-1:0] msd_idx;
    logic [3:0]       msd;

    // New number enters the converter only while it sits idle.
    assign o_stall   = !conv_idle;
    assign in_accept = i_valid && !o_stall;

    sitd_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_value  (i_value),
        .i_take   (conv_take),
        .o_idle   (conv_idle),
        .o_done   (conv_done),
        .o_result (conv_res)
    );

    assign out_accept = r_ebusy && !i_stall;
    // Hand over when the emitter is empty or is sending its final character.
    assign conv_take  = conv_done && (!r_ebusy || (out_accept && o_last));

    // Most significant remaining digit sits at a fixed slot for the whole number;
    // the line shifts up one digit per digit character sent.
    always_comb begin
        msd_idx = NdigW'(r_endig - 1'b1);
        msd     = 4'd0;
        for (int i = 0; i < NumDigits; i++) begin
            if (NdigW'(i) == msd_idx) begin
                msd = r_edig[4*i +: 4];
            end
        end
    end

    assign o_valid     = r_ebusy;
    assign o_char_code = r_sign_pend ? CHAR_MINUS : CharW'(CHAR_ZERO + {4'd0, msd});
    assign o_last      = (r_rem == LenW'(1));
    assign o_length    = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ebusy     <= 1'b0;
            r_sign_pend <= 1'b0;
            r_rem       <= '0;
            r_len       <= '0;
            r_endig     <= NdigW'(1);
        end else begin
            r_ebusy     <= n_ebusy;
            r_sign_pend <= n_sign_pend;
            r_rem       <= n_rem;
            r_len       <= n_len;
            r_endig     <= n_endig;
        end
        r_edig <= n_edig;
    end

    always_comb begin
        n_ebusy     = r_ebusy;
        n_edig      = r_edig;
        n_endig     = r_endig;
        n_sign_pend = r_sign_pend;
        n_len       = r_len;
        n_rem       = r_rem;
        priority if (conv_take) begin
            n_ebusy     = 1'b1;
            n_edig      = conv_res.bcd;
            n_endig     = conv_res.ndig;
            n_sign_pend = conv_res.neg;
            n_len       = LenW'(conv_res.ndig + conv_res.neg);
            n_rem       = LenW'(conv_res.ndig + conv_res.neg);
        end else if (out_accept) begin
            n_rem = LenW'(r_rem - 1'b1);
            if (r_sign_pend) begin
                n_sign_pend = 1'b0;
            end else begin
                n_edig = {r_edig[BcdW-5:0], 4'd0};
            end
            if (o_last) begin
                n_ebusy = 1'b0;
            end
        end
    end

    // Characters left never exceed the text length while sending.
    `ASSERT_IMPL(a_rem_in_range, i_clk, i_rst_n, o_valid, (r_rem != '0) && (r_rem <= r_len))
    // The sign only ever leads the text.
    `ASSERT_IMPL(a_sign_first, i_clk, i_rst_n, r_sign_pend, (r_rem == r_len) && (r_len > LenW'(1)))
    // An accepted input transaction holds the converter busy next cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_stall)
    // A hand-over to an empty emitter, or to one sending its final character, restarts the emitter at once.
    `ASSERT_NEXT(a_handover, i_clk, i_rst_n, conv_take, o_valid && (r_rem == r_len))

endmodule

`default_nettype wire
